FILE: rtl/core/first_fit_record_allocator_assert.svh
// Assertion macros of the first-fit record allocator, used by ffra_ctrl.
// They expect signals named clk and rst_n in the module that uses them.
`ifndef FIRST_FIT_RECORD_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RECORD_ALLOCATOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FFRA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("allocator check failed");

// A consequence that must hold in the same cycle as its cause.
`define FFRA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

`endif

FILE: rtl/core/ffra_pkg.sv
// Shared types and constants of the first-fit record allocator.
// Used by the channel interfaces, the table cells and the control unit.
package ffra_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned DATA_WORDS    = 65536;

  localparam int unsigned IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned OFF_W   = $clog2(DATA_WORDS) + 1;
  localparam int unsigned SUM_W   = OFF_W + 1;
  localparam int unsigned REQ_W   = 13;
  localparam int unsigned NUM_W   = 7;
  localparam int unsigned ROFF_W  = 16;
  localparam int unsigned STS_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(TABLE_ENTRIES);
  localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(DATA_WORDS);
  localparam logic [OFF_W-1:0] TAIL_MAX = OFF_W'(DATA_WORDS);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_BAD   = 2'd2;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD_IDX = 2'd2;
  localparam logic [STS_W-1:0] STS_NOSPACE = 2'd3;

  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic [REQ_W-1:0] req;
    logic [CNT_W-1:0] tgt;
    logic [CNT_W-1:0] idx;
    logic             app_ok;
    logic             hit;
    logic             reuse;
    logic             last;
    logic [OFF_W-1:0] off;
    logic [CNT_W-1:0] slot;
  } wave_t;

endpackage

FILE: rtl/core/ffra_if.sv
// Valid/ready channel interfaces of the first-fit record allocator.
// Depends on ffra_pkg for the field widths.
interface ffra_in_if;
  import ffra_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic [REQ_W-1:0] request_size;
  logic [NUM_W-1:0] entry_number;

  modport source (output valid, mode, request_size, entry_number, input ready);
  modport sink (input valid, mode, request_size, entry_number, output ready);
endinterface

interface ffra_out_if;
  import ffra_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROFF_W-1:0] region_offset;
  logic [NUM_W-1:0]  slot_number;
  logic              reused;
  logic [STS_W-1:0]  status;

  modport source (output valid, region_offset, slot_number, reused, status, input ready);
  modport sink (input valid, region_offset, slot_number, reused, status, output ready);
endinterface

FILE: rtl/core/first_fit_record_allocator.sv
// First-fit record allocator: the top level, built from the control unit
// and a row of table cells. Depends on ffra_pkg, the channel interfaces,
// ffra_ctrl and ffra_cell.
//
// The input channel in_chan carries one request word: mode 0 allocates
// request_size words, mode 1 deletes the 1-based entry entry_number. The
// result channel out_chan returns one word per request with the region
// offset, the slot used, the reuse flag and a status code.
// Each request travels as a wave down the row of table entries, one entry
// per cycle; the first deleted entry that fits is reused, or the entry just
// past the last live one is appended. The accepted word is registered as a
// launch wave, passes the register of each table cell in turn and returns
// to the control unit, which registers the result word. One request is handled
// at a time. A stalled receiver holds the result word steady and no new
// request is taken until it is accepted.
// Reset empties the table at once: the entry count and the end of the
// word space in use return to zero, and no clearing pass is needed.
module first_fit_record_allocator (
  input  logic        clk,
  input  logic        rst_n,
  ffra_in_if.sink     in_chan,
  ffra_out_if.source  out_chan
);
  import ffra_pkg::*;

  wave_t            wave [TABLE_ENTRIES+1];
  logic [CNT_W-1:0] cnt;

  ffra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cnt_o    (cnt),
    .launch_o (wave[0]),
    .ret_i    (wave[TABLE_ENTRIES])
  );

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ffra_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cnt_i  (cnt),
      .wave_i (wave[g]),
      .wave_o (wave[g+1])
    );
  end

endmodule

FILE: rtl/core/ffra_cell.sv
// One table entry of the allocator: holds offset, size and deleted mark.
// Applies the passing request wave to its entry and hands it on. Uses ffra_pkg.
module ffra_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ffra_pkg::CNT_W-1:0] cnt_i,
  input  ffra_pkg::wave_t           wave_i,
  output ffra_pkg::wave_t           wave_o
);
  import ffra_pkg::*;

  logic [OFF_W-1:0] off_r, off_nxt;
  logic [REQ_W-1:0] size_r, size_nxt;
  logic             del_r, del_nxt;
  wave_t            wave_r, wave_nxt;
  logic [CNT_W-1:0] idx_inc;
  logic             live;

  assign idx_inc = wave_i.idx + CNT_W'(1);
  assign live    = wave_i.idx < cnt_i;

  always_comb begin
    wave_nxt     = wave_i;
    wave_nxt.idx = idx_inc;
    off_nxt      = off_r;
    size_nxt     = size_r;
    del_nxt      = del_r;
    if (wave_i.vld) begin
      case (wave_i.op)
        OP_ALLOC: begin
          if (!wave_i.hit) begin
            if (live && del_r && (wave_i.req <= size_r)) begin
              size_nxt       = wave_i.req;
              del_nxt        = 1'b0;
              wave_nxt.hit   = 1'b1;
              wave_nxt.reuse = 1'b1;
              wave_nxt.last  = (idx_inc == cnt_i);
              wave_nxt.off   = off_r;
              wave_nxt.slot  = idx_inc;
            end else if ((wave_i.idx == cnt_i) && wave_i.app_ok) begin
              off_nxt        = wave_i.off;
              size_nxt       = wave_i.req;
              del_nxt        = 1'b0;
              wave_nxt.hit   = 1'b1;
              wave_nxt.reuse = 1'b0;
              wave_nxt.last  = 1'b0;
              wave_nxt.slot  = idx_inc;
            end
          end
        end
        OP_DEL: begin
          if (wave_i.idx == wave_i.tgt) begin
            del_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    size_r <= size_nxt;
    del_r  <= del_nxt;
    if (!rst_n) begin
      wave_r.vld <= 1'b0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  assign wave_o = wave_r;

endmodule

FILE: rtl/core/ffra_ctrl.sv
// Control unit of the allocator: accepts words, launches request waves into
// the cell row, turns the returning wave into a result word. Uses ffra_pkg.
module ffra_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  ffra_in_if.sink                    in_chan,
  ffra_out_if.source                 out_chan,
  output logic [ffra_pkg::CNT_W-1:0] cnt_o,
  output ffra_pkg::wave_t            launch_o,
  input  ffra_pkg::wave_t            ret_i
);
  import ffra_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BUSY = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OFF_W-1:0]  tail_r, tail_nxt;
  wave_t             launch_r, launch_nxt;
  logic [ROFF_W-1:0] roff_r, roff_nxt;
  logic [NUM_W-1:0]  slot_r, slot_nxt;
  logic              reused_r, reused_nxt;
  logic [STS_W-1:0]  sts_r, sts_nxt;
  logic              accept;
  logic [SUM_W-1:0]  need;
  logic [CNT_W-1:0]  num;

  assign accept = in_chan.valid && in_chan.ready;
  assign need   = SUM_W'(tail_r) + SUM_W'(in_chan.request_size);
  assign num    = CNT_W'(in_chan.entry_number);

  always_comb begin
    launch_nxt        = launch_r;
    launch_nxt.vld    = 1'b0;
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    tail_nxt          = tail_r;
    roff_nxt          = roff_r;
    slot_nxt          = slot_r;
    reused_nxt        = reused_r;
    sts_nxt           = sts_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          launch_nxt.vld    = 1'b1;
          launch_nxt.req    = in_chan.request_size;
          launch_nxt.tgt    = num - CNT_W'(1);
          launch_nxt.idx    = '0;
          launch_nxt.app_ok = (cnt_r < CNT_MAX) && (need <= SUM_MAX);
          launch_nxt.hit    = 1'b0;
          launch_nxt.reuse  = 1'b0;
          launch_nxt.last   = 1'b0;
          launch_nxt.off    = tail_r;
          launch_nxt.slot   = '0;
          if (!in_chan.mode) begin
            launch_nxt.op = OP_ALLOC;
          end else if ((num == '0) || (num > cnt_r)) begin
            launch_nxt.op = OP_BAD;
          end else begin
            launch_nxt.op = OP_DEL;
          end
          state_nxt = S_BUSY;
        end
      end
      S_BUSY: begin
        if (ret_i.vld) begin
          roff_nxt   = '0;
          slot_nxt   = '0;
          reused_nxt = 1'b0;
          sts_nxt    = STS_OK;
          case (ret_i.op)
            OP_DEL: begin
              slot_nxt = NUM_W'(ret_i.tgt + CNT_W'(1));
            end
            OP_ALLOC: begin
              if (ret_i.hit) begin
                roff_nxt   = ret_i.off[ROFF_W-1:0];
                slot_nxt   = NUM_W'(ret_i.slot);
                reused_nxt = ret_i.reuse;
                if (!ret_i.reuse) begin
                  cnt_nxt = cnt_r + CNT_W'(1);
                end
                if (!ret_i.reuse || ret_i.last) begin
                  tail_nxt = OFF_W'(SUM_W'(ret_i.off) + SUM_W'(ret_i.req));
                end
              end else if (cnt_r >= CNT_MAX) begin
                sts_nxt = STS_FULL;
              end else begin
                sts_nxt = STS_NOSPACE;
              end
            end
            default: begin
              sts_nxt = STS_BAD_IDX;
            end
          endcase
          state_nxt = S_SEND;
        end
      end
      S_SEND: begin
        if (out_chan.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    roff_r   <= roff_nxt;
    slot_r   <= slot_nxt;
    reused_r <= reused_nxt;
    sts_r    <= sts_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      tail_r       <= '0;
      launch_r.vld <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      tail_r   <= tail_nxt;
      launch_r <= launch_nxt;
    end
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = (state_r == S_SEND);
  assign out_chan.region_offset = roff_r;
  assign out_chan.slot_number   = slot_r;
  assign out_chan.reused        = reused_r;
  assign out_chan.status        = sts_r;
  assign cnt_o                  = cnt_r;
  assign launch_o               = launch_r;

`include "first_fit_record_allocator_assert.svh"

  // A wave only comes back while its item is in flight.
  `FFRA_ASSERT_IMPLY(a_ret_busy, ret_i.vld, state_r == S_BUSY)
  // The table and the word space never overflow.
  `FFRA_ASSERT_ALWAYS(a_bounds, (cnt_r <= CNT_MAX) && (tail_r <= TAIL_MAX))
  // Entries are only ever added one at a time, and only when a result is formed.
  `FFRA_ASSERT_IMPLY(a_cnt_step, cnt_r != $past(cnt_r),
    (cnt_r == $past(cnt_r) + CNT_W'(1)) && (state_r == S_SEND))

endmodule
